[hw/rtl/stq_pkg.sv]
`timescale 1ns / 1ps

package stq_pkg;

	localparam int SLOT_W = 9;
	localparam int OWNER_W = 8;
	localparam int DATA_W = 32;
	localparam logic [DATA_W-1:0] NO_DEADLINE = 32'hffff_ffff;

	typedef enum logic [2:0] {
		MODE_ALLOC      = 3'd0,
		MODE_FREE       = 3'd1,
		MODE_BIND       = 3'd2,
		MODE_ARM        = 3'd3,
		MODE_CANCEL     = 3'd4,
		MODE_CANCEL_ALL = 3'd5
	} mode_e;

	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_ALLOC = 2'd1,
		ST_COUNT = 2'd2
	} slot_status_e;

	typedef enum logic [2:0] {
		RD_TGT,
		RD_HEAD,
		RD_RDLINK,
		RD_SAVLINK,
		RD_IDX
	} rd_sel_e;

	typedef enum logic [1:0] {
		WA_TGT,
		WA_IDX,
		WA_PREV,
		WA_CUR
	} wr_sel_e;

	typedef enum logic [3:0] {
		WK_CLEAR,
		WK_ALLOC,
		WK_FREE,
		WK_BIND,
		WK_ARM,
		WK_PLINK,
		WK_CLINK,
		WK_UNC_ALLOC,
		WK_UNC_FREE
	} wr_kind_e;

	typedef struct packed {
		logic [2:0]         mode;
		logic [SLOT_W-1:0]  slot;
		logic [OWNER_W-1:0] owner_id;
		logic [DATA_W-1:0]  payload;
		logic               auto_cancel;
		logic [DATA_W-1:0]  delay;
		logic [DATA_W-1:0]  now_tick;
	} in_item_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] slot_out;
		logic [SLOT_W-1:0] head_slot;
		logic [DATA_W-1:0] earliest_deadline;
	} out_item_t;

	typedef struct packed {
		logic     in_load;
		logic     rd_en;
		rd_sel_e  rd_sel;
		logic     wr_en;
		wr_sel_e  wr_sel;
		wr_kind_e wr_kind;
		logic     idx_one;
		logic     idx_inc;
		logic     sav_load;
		logic     tgt_from_idx;
		logic     walk_start;
		logic     walk_step;
		logic     head_from_sav;
		logic     headdl_from_rd;
		logic     head_arm;
		logic     set_ok;
		logic     alloc_hit;
		logic     alloc_miss;
		logic     out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0]   mode;
		logic         valid;
		slot_status_e rd_status;
		logic         ca_match;
		logic         dl_le;
		logic         link_is_tgt;
		logic         tgt_is_head;
		logic         idx_last;
		logic         have_prev;
	} dp_stat_t;

endpackage

[hw/rtl/sorted_timer_queue_top.sv]
`timescale 1ns / 1ps
// channel   | valid      | stall      | payload
// request   | req_valid  | req_stall  | req  (stq_pkg::in_item_t)
// response  | rsp_valid  | rsp_stall  | rsp  (stq_pkg::out_item_t)
//
// one operation at a time; arm and cancel may walk the sorted list entry by entry
// on the single memory read port; allocate scans the pool slot by slot for a
// free slot, cancel-all scans every slot and walks the list for each counting
// slot it removes
// after reset a clearing pass over all TIMER_SLOTS entries holds req_stall high
// a held response does not block the next request transfer

module sorted_timer_queue_top #(
	parameter int TIMER_SLOTS = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  stq_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output stq_pkg::out_item_t rsp
);
	import stq_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	stq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	stq_datapath #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

[hw/rtl/stq_datapath.sv]
`timescale 1ns / 1ps

module stq_datapath #(
	parameter int TIMER_SLOTS = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stq_pkg::in_item_t  req,
	input  stq_pkg::ctl_cmd_t  cmd,
	output stq_pkg::dp_stat_t  stat,
	output stq_pkg::out_item_t rsp
);
	import stq_pkg::*;

	localparam int IW = $clog2(TIMER_SLOTS);

	typedef logic [IW-1:0] idx_t;

	typedef struct packed {
		slot_status_e       status;
		logic               mark;
		logic [OWNER_W-1:0] owner;
		logic [DATA_W-1:0]  payload;
		logic [DATA_W-1:0]  deadline;
		idx_t               link;
	} entry_t;

	entry_t mem_q [TIMER_SLOTS];

	logic [2:0]         mode_q;
	logic               valid_q;
	idx_t               tgt_q;
	logic [OWNER_W-1:0] owner_q;
	logic [DATA_W-1:0]  pay_q;
	logic               mark_q;
	logic [DATA_W-1:0]  dl_q;
	idx_t               idx_q;
	idx_t               cur_q;
	idx_t               prev_q;
	logic               have_prev_q;
	entry_t             sav_q;
	entry_t             prv_q;
	entry_t             rd_q;
	idx_t               head_q;
	logic [DATA_W-1:0]  headdl_q;
	logic               ok_q;
	logic [SLOT_W-1:0]  sout_q;
	out_item_t          rsp_q;

	idx_t   rd_addr;
	idx_t   wr_addr;
	entry_t wr_data;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_TGT:     rd_addr = tgt_q;
			RD_HEAD:    rd_addr = head_q;
			RD_RDLINK:  rd_addr = rd_q.link;
			RD_SAVLINK: rd_addr = sav_q.link;
			RD_IDX:     rd_addr = idx_q;
			default:    rd_addr = idx_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WA_TGT:  wr_addr = tgt_q;
			WA_IDX:  wr_addr = idx_q;
			WA_PREV: wr_addr = prev_q;
			WA_CUR:  wr_addr = cur_q;
			default: wr_addr = tgt_q;
		endcase
	end

	always_comb begin
		wr_data = rd_q;
		unique case (cmd.wr_kind)
			WK_CLEAR: begin
				wr_data.status   = (idx_q == '0) ? ST_COUNT : ST_FREE;
				wr_data.mark     = 1'b0;
				wr_data.owner    = '0;
				wr_data.payload  = '0;
				wr_data.deadline = NO_DEADLINE;
				wr_data.link     = '0;
			end
			WK_ALLOC: begin
				wr_data.status = ST_ALLOC;
				wr_data.mark   = 1'b0;
			end
			WK_FREE: wr_data.status = ST_FREE;
			WK_BIND: begin
				wr_data.owner   = owner_q;
				wr_data.payload = pay_q;
				wr_data.mark    = mark_q;
			end
			WK_ARM: begin
				wr_data          = sav_q;
				wr_data.status   = ST_COUNT;
				wr_data.deadline = dl_q;
				wr_data.link     = cur_q;
			end
			WK_PLINK: begin
				wr_data      = prv_q;
				wr_data.link = tgt_q;
			end
			WK_CLINK: wr_data.link = sav_q.link;
			WK_UNC_ALLOC: begin
				wr_data        = sav_q;
				wr_data.status = ST_ALLOC;
			end
			WK_UNC_FREE: begin
				wr_data        = sav_q;
				wr_data.status = ST_FREE;
			end
			default: wr_data = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// item registers and walk pointers
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			mode_q  <= req.mode;
			valid_q <= (req.slot != '0) && (32'(req.slot) < 32'(TIMER_SLOTS));
			tgt_q   <= IW'(req.slot);
			owner_q <= req.owner_id;
			pay_q   <= req.payload;
			mark_q  <= req.auto_cancel;
			dl_q    <= req.now_tick + req.delay;
		end else if (cmd.tgt_from_idx) begin
			tgt_q <= idx_q;
		end
		if (cmd.sav_load) begin
			sav_q <= rd_q;
		end
		if (cmd.walk_start) begin
			cur_q <= head_q;
		end else if (cmd.walk_step) begin
			cur_q  <= rd_q.link;
			prev_q <= cur_q;
			prv_q  <= rd_q;
		end
		if (cmd.out_load) begin
			rsp_q <= '{ok: ok_q, slot_out: sout_q, head_slot: SLOT_W'(head_q),
				earliest_deadline: headdl_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			have_prev_q <= 1'b0;
			head_q      <= '0;
			headdl_q    <= NO_DEADLINE;
			ok_q        <= 1'b0;
			sout_q      <= '0;
		end else begin
			if (cmd.idx_one) begin
				idx_q <= IW'(1);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.walk_start) begin
				have_prev_q <= 1'b0;
			end else if (cmd.walk_step) begin
				have_prev_q <= 1'b1;
			end
			if (cmd.head_from_sav) begin
				head_q <= sav_q.link;
			end else if (cmd.head_arm) begin
				head_q   <= tgt_q;
				headdl_q <= dl_q;
			end
			if (cmd.headdl_from_rd) begin
				headdl_q <= rd_q.deadline;
			end
			if (cmd.in_load) begin
				ok_q   <= 1'b0;
				sout_q <= req.slot;
			end else if (cmd.alloc_hit) begin
				ok_q   <= 1'b1;
				sout_q <= SLOT_W'(idx_q);
			end else if (cmd.alloc_miss) begin
				sout_q <= '0;
			end else if (cmd.set_ok) begin
				ok_q <= 1'b1;
			end
		end
	end

	always_comb begin
		stat.mode        = mode_q;
		stat.valid       = valid_q;
		stat.rd_status   = rd_q.status;
		stat.ca_match    = rd_q.mark && (rd_q.owner == owner_q) && (rd_q.status != ST_FREE);
		stat.dl_le       = dl_q <= rd_q.deadline;
		stat.link_is_tgt = rd_q.link == tgt_q;
		stat.tgt_is_head = tgt_q == head_q;
		stat.idx_last    = idx_q == IW'(TIMER_SLOTS - 1);
		stat.have_prev   = have_prev_q;
	end

	assign rsp = rsp_q;

endmodule

[hw/rtl/stq_ctrl.sv]
`timescale 1ns / 1ps

module stq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  stq_pkg::dp_stat_t stat,
	output stq_pkg::ctl_cmd_t cmd
);
	import stq_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_AL_RD,
		S_AL_CHK,
		S_FR_CHK,
		S_BD_WR,
		S_AR_CHK,
		S_AR_WALK,
		S_AR_W1,
		S_AR_W2,
		S_CN_CHK,
		S_CN_START,
		S_CN_HEAD,
		S_CN_WALK,
		S_CN_END,
		S_CA_RD,
		S_CA_CHK,
		S_CA_NEXT,
		S_FIN
	} state_e;

	state_e state_q;
	state_e state_d;
	logic   rsp_valid_q;
	logic   all_mode;
	logic   out_free;

	assign all_mode  = stat.mode == MODE_CANCEL_ALL;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WA_IDX;
				cmd.wr_kind = WK_CLEAR;
				if (stat.idx_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.in_load = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.rd_sel = RD_TGT;
				unique case (stat.mode)
					MODE_ALLOC: begin
						cmd.idx_one = 1'b1;
						state_d     = S_AL_RD;
					end
					MODE_FREE, MODE_BIND, MODE_ARM, MODE_CANCEL: begin
						if (!stat.valid) begin
							state_d = S_FIN;
						end else begin
							cmd.rd_en = 1'b1;
							unique case (stat.mode)
								MODE_FREE: state_d = S_FR_CHK;
								MODE_BIND: state_d = S_BD_WR;
								MODE_ARM:  state_d = S_AR_CHK;
								default:   state_d = S_CN_CHK;
							endcase
						end
					end
					MODE_CANCEL_ALL: begin
						cmd.set_ok  = 1'b1;
						cmd.idx_one = 1'b1;
						state_d     = S_CA_RD;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_AL_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = S_AL_CHK;
			end
			S_AL_CHK: begin
				if (stat.rd_status == ST_FREE) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_sel    = WA_IDX;
					cmd.wr_kind   = WK_ALLOC;
					cmd.alloc_hit = 1'b1;
					state_d       = S_FIN;
				end else if (stat.idx_last) begin
					cmd.alloc_miss = 1'b1;
					state_d        = S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_AL_RD;
				end
			end
			S_FR_CHK: begin
				if (stat.rd_status != ST_COUNT) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WA_TGT;
					cmd.wr_kind = WK_FREE;
					cmd.set_ok  = 1'b1;
				end
				state_d = S_FIN;
			end
			S_BD_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WA_TGT;
				cmd.wr_kind = WK_BIND;
				cmd.set_ok  = 1'b1;
				state_d     = S_FIN;
			end
			S_AR_CHK: begin
				if (stat.rd_status == ST_ALLOC) begin
					cmd.sav_load   = 1'b1;
					cmd.walk_start = 1'b1;
					cmd.rd_en      = 1'b1;
					cmd.rd_sel     = RD_HEAD;
					state_d        = S_AR_WALK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_AR_WALK: begin
				if (stat.dl_le) begin
					state_d = S_AR_W1;
				end else begin
					cmd.walk_step = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = RD_RDLINK;
				end
			end
			S_AR_W1: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WA_TGT;
				cmd.wr_kind = WK_ARM;
				if (stat.have_prev) begin
					state_d = S_AR_W2;
				end else begin
					cmd.head_arm = 1'b1;
					cmd.set_ok   = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_AR_W2: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WA_PREV;
				cmd.wr_kind = WK_PLINK;
				cmd.set_ok  = 1'b1;
				state_d     = S_FIN;
			end
			S_CN_CHK: begin
				if (stat.rd_status == ST_COUNT) begin
					cmd.sav_load = 1'b1;
					state_d      = S_CN_START;
				end else begin
					state_d = S_FIN;
				end
			end
			S_CN_START: begin
				cmd.rd_en = 1'b1;
				if (stat.tgt_is_head) begin
					cmd.head_from_sav = 1'b1;
					cmd.rd_sel        = RD_SAVLINK;
					state_d           = S_CN_HEAD;
				end else begin
					cmd.walk_start = 1'b1;
					cmd.rd_sel     = RD_HEAD;
					state_d        = S_CN_WALK;
				end
			end
			S_CN_HEAD, S_CN_END: begin
				cmd.headdl_from_rd = state_q == S_CN_HEAD;
				cmd.wr_en          = 1'b1;
				cmd.wr_sel         = WA_TGT;
				cmd.wr_kind        = all_mode ? WK_UNC_FREE : WK_UNC_ALLOC;
				if (all_mode) begin
					state_d = S_CA_NEXT;
				end else begin
					cmd.set_ok = 1'b1;
					state_d    = S_FIN;
				end
			end
			S_CN_WALK: begin
				if (stat.link_is_tgt) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WA_CUR;
					cmd.wr_kind = WK_CLINK;
					state_d     = S_CN_END;
				end else begin
					cmd.walk_step = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = RD_RDLINK;
				end
			end
			S_CA_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = S_CA_CHK;
			end
			S_CA_CHK: begin
				state_d = S_CA_NEXT;
				if (stat.ca_match) begin
					if (stat.rd_status == ST_COUNT) begin
						cmd.tgt_from_idx = 1'b1;
						cmd.sav_load     = 1'b1;
						state_d          = S_CN_START;
					end else begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WA_IDX;
						cmd.wr_kind = WK_FREE;
					end
				end
			end
			S_CA_NEXT: begin
				if (stat.idx_last) begin
					state_d = S_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_CA_RD;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/stq_checker.sv]
`timescale 1ns / 1ps

module stq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input stq_pkg::out_item_t rsp
);
	import stq_pkg::*;

	// held response keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one operation at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// sentinel at the head means no deadline
	a_sentinel_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.head_slot == '0) |-> rsp.earliest_deadline == NO_DEADLINE)
		else $error("sentinel head with a deadline");

	// response drops only after its transfer
	a_rsp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(!rsp_stall))
		else $error("response dropped without a transfer");

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (.*);

[tb/tb_sorted_timer_queue_top.sv]
`timescale 1ns / 1ps

module tb_sorted_timer_queue_top;
	import stq_pkg::*;

	localparam int SLOTS = 512;
	localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
	localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

	class timer_queue_board;
		slot_status_e status[SLOTS];
		bit mark[SLOTS];
		logic [OWNER_W-1:0] owner[SLOTS];
		logic [DATA_W-1:0] payload[SLOTS];
		logic [DATA_W-1:0] deadline[SLOTS];
		logic [SLOT_W-1:0] link[SLOTS];
		logic [SLOT_W-1:0] head;
		logic [DATA_W-1:0] head_dl;
		out_item_t pending[$];
		int errors;
		int results;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				status[i] = ST_FREE;
				mark[i] = 0;
				owner[i] = '0;
				payload[i] = '0;
				deadline[i] = '0;
				link[i] = '0;
			end
			status[0] = ST_COUNT;
			deadline[0] = NO_DEADLINE;
			head = '0;
			head_dl = NO_DEADLINE;
			errors = 0;
			results = 0;
		endfunction

		function int first_free();
			for (int i = 1; i < SLOTS; i++)
				if (status[i] == ST_FREE) return i;
			return 0;
		endfunction

		function void insert_sorted(int s, logic [DATA_W-1:0] dl);
			int cur;
			int prev;
			bit has_prev;
			cur = int'(head);
			prev = 0;
			has_prev = 0;
			deadline[s] = dl;
			status[s] = ST_COUNT;
			for (int g = 0; g < SLOTS; g++) begin
				if (dl <= deadline[cur]) break;
				prev = cur;
				has_prev = 1;
				cur = int'(link[cur]);
			end
			link[s] = SLOT_W'(cur);
			if (!has_prev) begin
				head = SLOT_W'(s);
				head_dl = dl;
			end else begin
				link[prev] = SLOT_W'(s);
			end
		endfunction

		function bit unlink(int s);
			int cur;
			if (s == 0 || status[s] != ST_COUNT) return 0;
			if (s == int'(head)) begin
				head = link[s];
				head_dl = deadline[head];
			end else begin
				cur = int'(head);
				for (int g = 0; g < SLOTS; g++) begin
					if (int'(link[cur]) == s) begin
						link[cur] = link[s];
						break;
					end
					cur = int'(link[cur]);
				end
			end
			status[s] = ST_ALLOC;
			return 1;
		endfunction

		function void note(in_item_t it);
			out_item_t r;
			int s;
			bit ok_slot;
			s = int'(it.slot);
			ok_slot = s != 0;
			r.ok = 0;
			r.slot_out = it.slot;
			case (it.mode)
				MODE_ALLOC: begin
					s = first_free();
					r.slot_out = SLOT_W'(s);
					if (s != 0) begin
						status[s] = ST_ALLOC;
						mark[s] = 0;
						r.ok = 1;
					end
				end
				MODE_FREE: if (ok_slot && status[s] != ST_COUNT) begin
					status[s] = ST_FREE;
					r.ok = 1;
				end
				MODE_BIND: if (ok_slot) begin
					owner[s] = it.owner_id;
					payload[s] = it.payload;
					mark[s] = it.auto_cancel;
					r.ok = 1;
				end
				MODE_ARM: if (ok_slot && status[s] == ST_ALLOC) begin
					insert_sorted(s, it.now_tick + it.delay);
					r.ok = 1;
				end
				MODE_CANCEL: if (ok_slot) r.ok = unlink(s);
				MODE_CANCEL_ALL: begin
					for (int i = 1; i < SLOTS; i++)
						if (status[i] != ST_FREE && mark[i] && owner[i] == it.owner_id) begin
							void'(unlink(i));
							status[i] = ST_FREE;
						end
					r.ok = 1;
				end
				default: ;
			endcase
			r.head_slot = head;
			r.earliest_deadline = head_dl;
			pending.push_back(r);
		endfunction

		task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
			$display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
			errors++;
		endtask

		task check(out_item_t r);
			out_item_t e;
			results++;
			if (pending.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				errors++;
			end else begin
				e = pending.pop_front();
				if (r.ok !== e.ok) report("ok", DATA_W'(r.ok), DATA_W'(e.ok));
				if (r.slot_out !== e.slot_out)
					report("slot_out", DATA_W'(r.slot_out), DATA_W'(e.slot_out));
				if (r.head_slot !== e.head_slot)
					report("head_slot", DATA_W'(r.head_slot), DATA_W'(e.head_slot));
				if (r.earliest_deadline !== e.earliest_deadline)
					report("earliest_deadline", r.earliest_deadline, e.earliest_deadline);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	in_item_t req;
	logic rsp_valid;
	logic rsp_stall;
	out_item_t rsp;

	timer_queue_board board;
	bit tx_steady;
	bit rx_steady;
	int sent;
	int slot_hi;
	int mode_seen[8];

	sorted_timer_queue_top #(.TIMER_SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function in_item_t op(logic [2:0] m, int s, int own, logic [31:0] pay, bit mk,
			logic [31:0] dly, logic [31:0] now);
		in_item_t it;
		it.mode = m;
		it.slot = SLOT_W'(s);
		it.owner_id = OWNER_W'(own);
		it.payload = pay;
		it.auto_cancel = mk;
		it.delay = dly;
		it.now_tick = now;
		return it;
	endfunction

	task send(in_item_t it);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req <= it;
		req_valid <= 1;
		do @(posedge clk); while (!(req_valid && !req_stall));
		board.note(it);
		mode_seen[it.mode]++;
		sent++;
		if (sent % 64 == 0) tx_steady = $urandom_range(0, 3) == 0;
	endtask

	function in_item_t random_op();
		int w;
		logic [2:0] m;
		int s;
		logic [31:0] dly;
		logic [31:0] now;
		w = $urandom_range(0, 99);
		if (w < 20) m = MODE_ALLOC;
		else if (w < 35) m = MODE_FREE;
		else if (w < 55) m = MODE_BIND;
		else if (w < 80) m = MODE_ARM;
		else if (w < 94) m = MODE_CANCEL;
		else if (w < 98) m = MODE_CANCEL_ALL;
		else m = w[0] ? MODE_UNUSED_6 : MODE_UNUSED_7;
		s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(1, slot_hi);
		if ($urandom_range(0, 2) == 0) begin
			dly = $urandom_range(0, 3);
			now = $urandom_range(0, 3);
		end else begin
			dly = $urandom;
			now = $urandom;
		end
		return op(m, s, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3),
			$urandom, $urandom_range(0, 1), dly, now);
	endfunction

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall) board.check(rsp);

	initial begin
		int n;
		rsp_stall = 0;
		rx_steady = 0;
		@(posedge arst_n);
		forever begin
			n = rx_steady ? 0 : $urandom_range(0, 12);
			if (n > 0) begin
				rsp_stall <= 1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
			if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
		end
	end

	initial begin
		#200_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int spin;
		board = new();
		clk = 0;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		tx_steady = 0;
		sent = 0;
		slot_hi = 40;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed corners
		send(op(MODE_ALLOC, 0, 0, 0, 0, 0, 0));
		send(op(MODE_ALLOC, 511, 0, 0, 0, 0, 0));
		send(op(MODE_ALLOC, 0, 0, 0, 0, 0, 0));
		send(op(MODE_FREE, 0, 0, 0, 0, 0, 0));
		send(op(MODE_BIND, 0, 8'hff, 32'hffff_ffff, 1, 0, 0));
		send(op(MODE_ARM, 0, 0, 0, 0, 5, 0));
		send(op(MODE_CANCEL, 0, 0, 0, 0, 0, 0));
		send(op(MODE_FREE, 511, 0, 0, 0, 0, 0));
		send(op(MODE_BIND, 1, 8'hff, 32'hffff_ffff, 1, 0, 0));
		send(op(MODE_ARM, 1, 0, 0, 0, 2, 32'hffff_ffff));
		send(op(MODE_ARM, 2, 0, 0, 0, 1, 0));
		send(op(MODE_ARM, 3, 0, 0, 0, 32'hffff_ffff, 0));
		send(op(MODE_ARM, 2, 0, 0, 0, 7, 0));
		send(op(MODE_FREE, 2, 0, 0, 0, 0, 0));
		send(op(MODE_CANCEL, 3, 0, 0, 0, 0, 0));
		send(op(MODE_CANCEL, 3, 0, 0, 0, 0, 0));
		send(op(MODE_ARM, 4, 0, 0, 0, 9, 9));
		send(op(MODE_UNUSED_6, 5, 0, 0, 0, 0, 0));
		send(op(MODE_UNUSED_7, 511, 0, 0, 0, 0, 0));
		send(op(MODE_CANCEL_ALL, 6, 8'hff, 0, 0, 0, 0));
		send(op(MODE_CANCEL, 2, 0, 0, 0, 0, 0));
		send(op(MODE_FREE, 2, 0, 0, 0, 0, 0));
		send(op(MODE_FREE, 3, 0, 0, 0, 0, 0));
		send(op(MODE_BIND, 2, 0, 0, 0, 0, 0));

		repeat (550) send(random_op());

		// drive the pool to exhaustion
		while (board.first_free() != 0)
			send(op(MODE_ALLOC, $urandom_range(0, 511), 0, 0, 0, 0, 0));
		repeat (3) send(op(MODE_ALLOC, $urandom_range(0, 511), 0, 0, 0, 0, 0));

		slot_hi = 511;
		repeat (150) send(random_op());
		req_valid <= 0;

		spin = 0;
		while (board.pending.size() != 0 && spin < 2_000_000) begin
			@(posedge clk);
			spin++;
		end
		repeat (50) @(posedge clk);
		if (board.pending.size() != 0) begin
			$display("%0d results never arrived", board.pending.size());
			board.errors++;
		end

		$display("%0d operations, %0d results: alloc %0d free %0d bind %0d arm %0d", sent,
			board.results, mode_seen[MODE_ALLOC], mode_seen[MODE_FREE], mode_seen[MODE_BIND],
			mode_seen[MODE_ARM]);
		$display("cancel %0d, cancel-all %0d, unused modes %0d, pool exhaustion reached",
			mode_seen[MODE_CANCEL], mode_seen[MODE_CANCEL_ALL],
			mode_seen[MODE_UNUSED_6] + mode_seen[MODE_UNUSED_7]);
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
